### rtl/sat_branching_heuristic_scorer_assert.svh
// ----------------------------------------------------------------------------
// SAT branching heuristic scorer assertion macros
// Concurrent assertion shorthands clocked on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef SAT_BRANCHING_HEURISTIC_SCORER_ASSERT_SVH
`define SAT_BRANCHING_HEURISTIC_SCORER_ASSERT_SVH

// same-cycle implication, off during reset
`define SBHS_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbhs assertion failed");

// next-cycle implication, off during reset
`define SBHS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbhs assertion failed");

// holds at the edge after a reset edge
`define SBHS_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("sbhs assertion failed after reset");

`endif

### rtl/sbhs_pkg.sv
// ----------------------------------------------------------------------------
// SAT branching heuristic scorer package
// Shared constants, payload types, mode codes and the clause weight function.
// ----------------------------------------------------------------------------
package sbhs_pkg;

  localparam int WEIGHT_SIZE_DEF   = 5;
  localparam int B_ALPHA           = 1;
  localparam int B_BETA            = 2;

  localparam int VAR_ID_BITS       = 16;
  localparam int COUNT_BITS_DEF    = 20;
  localparam int WEIGHT_BITS       = 24;
  localparam int BEST_WEIGHT_BITS  = 25;
  localparam int SCORE_BITS        = 41;
  localparam int CLAUSE_BITS       = 20;
  localparam int FREE_BITS         = 8;
  localparam int MODE_BITS         = 3;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int CFG_DATA_BITS     = 20;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [CLAUSE_BITS-1:0]    CLAUSE_COUNT_RESET = '1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HEURISTIC_MODE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLAUSE_COUNT   = 2'd1;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ONE_SIDED = 3'd0,
    MODE_TWO_SIDED = 3'd1,
    MODE_MOMS      = 3'd2,
    MODE_BOHM      = 3'd3,
    MODE_DLIS      = 3'd4,
    MODE_DLCS      = 3'd5
  } mode_t;

  typedef struct packed {
    logic [VAR_ID_BITS-1:0] var_index;
    logic                   var_unassigned;
    logic                   has_occurrence;
    logic                   lit_negative;
    logic                   clause_satisfied;
    logic [FREE_BITS-1:0]   free_count;
    logic                   var_last;
    logic                   scan_last;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [VAR_ID_BITS-1:0] chosen_var;
    logic                   chosen_value;
  } out_item_t;

  typedef struct packed {
    logic [VAR_ID_BITS-1:0] var_index;
    logic                   acc;
    logic                   lit_negative;
    logic [FREE_BITS-1:0]   free_count;
    logic                   var_end;
    logic                   do_score;
    logic                   scan_end;
    mode_t                  mode;
  } entry_t;

  typedef struct packed {
    logic [VAR_ID_BITS-1:0] var_index;
    logic                   do_score;
    logic                   scan_end;
    mode_t                  mode;
  } req_ctrl_t;

  function automatic logic [WEIGHT_BITS-1:0] clause_weight(
    input logic [FREE_BITS-1:0] f,
    input int                   ws
  );
    logic [WEIGHT_BITS-1:0] w;
    w = '0;
    if ((int'(f) >= 1) && (int'(f) <= ws)) begin
      w = WEIGHT_BITS'(1) << (ws - int'(f));
    end
    return w;
  endfunction

endpackage

### rtl/sbhs_front.sv
// ----------------------------------------------------------------------------
// SAT branching heuristic scorer front end
// Decodes the mode and classifies one occurrence for the back end.
// ----------------------------------------------------------------------------
module sbhs_front #(
  parameter int WEIGHT_SIZE = sbhs_pkg::WEIGHT_SIZE_DEF
) (
  input  sbhs_pkg::in_item_t                 in_item,
  input  logic [sbhs_pkg::MODE_BITS-1:0]     mode_raw,
  output sbhs_pkg::entry_t                   entry
);

  sbhs_pkg::mode_t mode;
  logic            weighted;
  logic            too_long;

  always_comb begin
    if (mode_raw inside {[sbhs_pkg::MODE_ONE_SIDED:sbhs_pkg::MODE_DLCS]}) begin
      mode = sbhs_pkg::mode_t'(mode_raw);
    end else begin
      mode = sbhs_pkg::MODE_ONE_SIDED;
    end
  end

  assign weighted = (mode == sbhs_pkg::MODE_ONE_SIDED) || (mode == sbhs_pkg::MODE_TWO_SIDED);
  assign too_long = in_item.free_count > sbhs_pkg::FREE_BITS'(WEIGHT_SIZE);

  always_comb begin
    entry.var_index    = in_item.var_index;
    entry.acc          = in_item.var_unassigned && in_item.has_occurrence &&
                         !in_item.clause_satisfied && !(weighted && too_long);
    entry.lit_negative = in_item.lit_negative;
    entry.free_count   = in_item.free_count;
    entry.var_end      = in_item.var_last || in_item.scan_last;
    entry.do_score     = (in_item.var_last || in_item.scan_last) && in_item.var_unassigned;
    entry.scan_end     = in_item.scan_last;
    entry.mode         = mode;
  end

endmodule

### rtl/sbhs_queue.sv
// ----------------------------------------------------------------------------
// SAT branching heuristic scorer queue
// Short register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module sbhs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sbhs_pkg::entry_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output sbhs_pkg::entry_t head
);

  localparam int DEPTH    = sbhs_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS = $clog2(DEPTH);

  sbhs_pkg::entry_t      mem_r [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r;
  logic [PTR_BITS-1:0]   rd_ptr_r;
  logic [PTR_BITS:0]     count_r;

  assign full  = count_r == (PTR_BITS+1)'(DEPTH);
  assign empty = count_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_BITS'(1);
      end
      count_r <= count_r + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
    end
  end

endmodule

### rtl/sbhs_accum.sv
// ----------------------------------------------------------------------------
// SAT branching heuristic scorer accumulator
// Gathers per-variable counts, weights and smallest free count; hands the
// totals to the selector at each variable end.
// ----------------------------------------------------------------------------
module sbhs_accum #(
  parameter int WEIGHT_SIZE = sbhs_pkg::WEIGHT_SIZE_DEF,
  parameter int COUNT_BITS  = sbhs_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                advance,
  input  logic                                entry_vld,
  input  sbhs_pkg::entry_t                    entry,
  input  logic [sbhs_pkg::CLAUSE_BITS-1:0]    clause_count,
  output logic                                pop,
  output logic                                req_vld_r,
  output sbhs_pkg::req_ctrl_t                 req_ctrl_r,
  output logic [COUNT_BITS-1:0]               req_pos_count_r,
  output logic [COUNT_BITS-1:0]               req_neg_count_r,
  output logic [sbhs_pkg::WEIGHT_BITS-1:0]    req_pos_weight_r,
  output logic [sbhs_pkg::WEIGHT_BITS-1:0]    req_neg_weight_r,
  output logic [sbhs_pkg::CLAUSE_BITS-1:0]    req_min_free_r
);

  localparam int WB = sbhs_pkg::WEIGHT_BITS;
  localparam int CL = sbhs_pkg::CLAUSE_BITS;

  logic [COUNT_BITS-1:0] pos_count_r, neg_count_r;
  logic [WB-1:0]         pos_weight_r, neg_weight_r;
  logic [CL-1:0]         var_min_free_r;

  logic [COUNT_BITS-1:0] pos_count_nxt, neg_count_nxt;
  logic [WB-1:0]         pos_weight_nxt, neg_weight_nxt;
  logic [CL-1:0]         var_min_free_nxt;

  logic [COUNT_BITS-1:0] acc_pc, acc_nc;
  logic [WB-1:0]         acc_pw, acc_nw;
  logic [CL-1:0]         acc_min;

  logic [COUNT_BITS-1:0] pc_inc, nc_inc;
  logic [WB-1:0]         w;
  logic [WB:0]           pw_sum, nw_sum;
  logic [WB-1:0]         pw_add, nw_add;
  logic [CL-1:0]         free_ext;
  logic                  less, same;

  assign pop      = advance && entry_vld;
  assign w        = sbhs_pkg::clause_weight(entry.free_count, WEIGHT_SIZE);
  assign pc_inc   = (&pos_count_r) ? pos_count_r : pos_count_r + COUNT_BITS'(1);
  assign nc_inc   = (&neg_count_r) ? neg_count_r : neg_count_r + COUNT_BITS'(1);
  assign pw_sum   = {1'b0, pos_weight_r} + {1'b0, w};
  assign nw_sum   = {1'b0, neg_weight_r} + {1'b0, w};
  assign pw_add   = pw_sum[WB] ? '1 : pw_sum[WB-1:0];
  assign nw_add   = nw_sum[WB] ? '1 : nw_sum[WB-1:0];
  assign free_ext = CL'(entry.free_count);
  assign less     = free_ext < var_min_free_r;
  assign same     = free_ext == var_min_free_r;

  always_comb begin
    acc_pc  = pos_count_r;
    acc_nc  = neg_count_r;
    acc_pw  = pos_weight_r;
    acc_nw  = neg_weight_r;
    acc_min = var_min_free_r;
    if (entry.acc) begin
      case (entry.mode)
        sbhs_pkg::MODE_ONE_SIDED, sbhs_pkg::MODE_TWO_SIDED: begin
          if (!entry.lit_negative) begin
            acc_pc = pc_inc;
            acc_pw = pw_add;
          end else begin
            acc_nc = nc_inc;
            acc_nw = nw_add;
          end
        end
        sbhs_pkg::MODE_MOMS, sbhs_pkg::MODE_BOHM: begin
          if (!entry.lit_negative) begin
            if (less) begin
              acc_min = free_ext;
              acc_pc  = COUNT_BITS'(1);
            end else if (same) begin
              acc_pc = pc_inc;
            end
            acc_pw = pw_add;
          end else begin
            if (less) begin
              acc_min = free_ext;
              acc_nc  = COUNT_BITS'(1);
              acc_pc  = '0;
            end else if (same) begin
              acc_nc = nc_inc;
            end
            acc_nw = nw_add;
          end
        end
        default: begin
          if (!entry.lit_negative) begin
            acc_pc = pc_inc;
          end else begin
            acc_nc = nc_inc;
          end
        end
      endcase
    end
  end

  always_comb begin
    pos_count_nxt    = pos_count_r;
    neg_count_nxt    = neg_count_r;
    pos_weight_nxt   = pos_weight_r;
    neg_weight_nxt   = neg_weight_r;
    var_min_free_nxt = var_min_free_r;
    if (pop) begin
      if (entry.var_end) begin
        pos_count_nxt    = '0;
        neg_count_nxt    = '0;
        pos_weight_nxt   = '0;
        neg_weight_nxt   = '0;
        var_min_free_nxt = clause_count;
      end else begin
        pos_count_nxt    = acc_pc;
        neg_count_nxt    = acc_nc;
        pos_weight_nxt   = acc_pw;
        neg_weight_nxt   = acc_nw;
        var_min_free_nxt = acc_min;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_count_r    <= '0;
      neg_count_r    <= '0;
      pos_weight_r   <= '0;
      neg_weight_r   <= '0;
      var_min_free_r <= sbhs_pkg::CLAUSE_COUNT_RESET;
      req_vld_r      <= 1'b0;
    end else begin
      pos_count_r    <= pos_count_nxt;
      neg_count_r    <= neg_count_nxt;
      pos_weight_r   <= pos_weight_nxt;
      neg_weight_r   <= neg_weight_nxt;
      var_min_free_r <= var_min_free_nxt;
      if (advance) begin
        req_vld_r <= pop && entry.var_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && entry.var_end) begin
      req_ctrl_r.var_index <= entry.var_index;
      req_ctrl_r.do_score  <= entry.do_score;
      req_ctrl_r.scan_end  <= entry.scan_end;
      req_ctrl_r.mode      <= entry.mode;
      req_pos_count_r      <= acc_pc;
      req_neg_count_r      <= acc_nc;
      req_pos_weight_r     <= acc_pw;
      req_neg_weight_r     <= acc_nw;
      req_min_free_r       <= acc_min;
    end
  end

endmodule

### rtl/sbhs_select.sv
// ----------------------------------------------------------------------------
// SAT branching heuristic scorer selector
// Scores each finished variable over two stages, keeps the best candidate
// and registers the decision at the scan end.
// ----------------------------------------------------------------------------
module sbhs_select #(
  parameter int COUNT_BITS = sbhs_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                advance,
  input  logic [sbhs_pkg::CLAUSE_BITS-1:0]    clause_count,
  input  logic                                req_vld,
  input  sbhs_pkg::req_ctrl_t                 req_ctrl,
  input  logic [COUNT_BITS-1:0]               req_pos_count,
  input  logic [COUNT_BITS-1:0]               req_neg_count,
  input  logic [sbhs_pkg::WEIGHT_BITS-1:0]    req_pos_weight,
  input  logic [sbhs_pkg::WEIGHT_BITS-1:0]    req_neg_weight,
  input  logic [sbhs_pkg::CLAUSE_BITS-1:0]    req_min_free,
  output logic                                out_valid_r,
  output sbhs_pkg::out_item_t                 out_data_r
);

  localparam int WB  = sbhs_pkg::WEIGHT_BITS;
  localparam int BWB = sbhs_pkg::BEST_WEIGHT_BITS;
  localparam int SB  = sbhs_pkg::SCORE_BITS;
  localparam int CL  = sbhs_pkg::CLAUSE_BITS;
  localparam int VB  = sbhs_pkg::VAR_ID_BITS;
  localparam int TB  = ((COUNT_BITS > WB) ? COUNT_BITS : WB) + 1;
  localparam int PB  = 2 * COUNT_BITS;
  localparam int PW  = (PB > SB) ? PB : SB;
  localparam int HB  = COUNT_BITS + 2;
  localparam logic [SB-1:0] SCORE_MAX = '1;

  // score stage
  logic                 s2_vld_r;
  sbhs_pkg::req_ctrl_t  ctrl_r;
  logic [PB-1:0]        prod_r;
  logic [COUNT_BITS:0]  pn_r;
  logic [HB-1:0]        bohm_r;
  logic [TB-1:0]        t_r, f_r;
  logic [BWB-1:0]       wsum_r;
  logic                 p_gt_n_r;
  logic [CL-1:0]        min_free_r;

  logic [TB-1:0]         t_cmb, f_cmb;
  logic [COUNT_BITS-1:0] mx, mn;

  // best-so-far
  logic [SB-1:0]  best_score_r, best_score_nxt;
  logic           bs_vld_r, bs_vld_nxt;
  logic [BWB-1:0] best_weight_r, best_weight_nxt;
  logic           bw_vld_r, bw_vld_nxt;
  logic [CL-1:0]  best_min_free_r, best_min_free_nxt;
  logic [VB-1:0]  best_var_r, best_var_nxt;
  logic           best_value_r, best_value_nxt;
  logic           have_best_r, have_best_nxt;
  logic           out_valid_nxt;
  sbhs_pkg::out_item_t out_data_nxt;

  logic [SB-1:0]  prod_sat, h_moms, h_sel, s_sum;
  logic [SB:0]    moms_sum;
  logic [SB-1:0]  t_ext, f_ext;
  logic           t_gt, f_gt, s_gt, h_gt, h_eq, w_gt, mf_lt, mf_eq;

  always_comb begin
    case (req_ctrl.mode)
      sbhs_pkg::MODE_ONE_SIDED, sbhs_pkg::MODE_TWO_SIDED: begin
        t_cmb = TB'(req_pos_count) + TB'(req_neg_weight);
        f_cmb = TB'(req_neg_count) + TB'(req_pos_weight);
      end
      default: begin
        t_cmb = TB'(req_pos_count);
        f_cmb = TB'(req_neg_count);
      end
    endcase
  end

  assign mx = (req_pos_count > req_neg_count) ? req_pos_count : req_neg_count;
  assign mn = (req_pos_count < req_neg_count) ? req_pos_count : req_neg_count;

  always_ff @(posedge clk) begin
    if (advance && req_vld) begin
      ctrl_r     <= req_ctrl;
      prod_r     <= PB'(req_pos_count) * PB'(req_neg_count);
      pn_r       <= (COUNT_BITS+1)'(req_pos_count) + (COUNT_BITS+1)'(req_neg_count);
      bohm_r     <= HB'(mx) * HB'(sbhs_pkg::B_ALPHA) + HB'(mn) * HB'(sbhs_pkg::B_BETA);
      t_r        <= t_cmb;
      f_r        <= f_cmb;
      wsum_r     <= BWB'(req_pos_weight) + BWB'(req_neg_weight);
      p_gt_n_r   <= req_pos_count > req_neg_count;
      min_free_r <= req_min_free;
    end
  end

  assign prod_sat = (PW'(prod_r) > PW'(SCORE_MAX)) ? SCORE_MAX : SB'(prod_r);
  assign moms_sum = (SB+1)'(prod_sat) + (SB+1)'(pn_r);
  assign h_moms   = moms_sum[SB] ? SCORE_MAX : moms_sum[SB-1:0];
  assign h_sel    = (ctrl_r.mode == sbhs_pkg::MODE_MOMS) ? h_moms : SB'(bohm_r);
  assign t_ext    = SB'(t_r);
  assign f_ext    = SB'(f_r);
  assign s_sum    = t_ext + f_ext;

  assign t_gt  = !bs_vld_r || (t_ext > best_score_r);
  assign f_gt  = !bs_vld_r || (f_ext > best_score_r);
  assign s_gt  = !bs_vld_r || (s_sum > best_score_r);
  assign h_gt  = !bs_vld_r || (h_sel > best_score_r);
  assign h_eq  = bs_vld_r && (h_sel == best_score_r);
  assign w_gt  = !bw_vld_r || (wsum_r > best_weight_r);
  assign mf_lt = min_free_r < best_min_free_r;
  assign mf_eq = min_free_r == best_min_free_r;

  always_comb begin
    best_score_nxt    = best_score_r;
    bs_vld_nxt        = bs_vld_r;
    best_weight_nxt   = best_weight_r;
    bw_vld_nxt        = bw_vld_r;
    best_min_free_nxt = best_min_free_r;
    best_var_nxt      = best_var_r;
    best_value_nxt    = best_value_r;
    have_best_nxt     = have_best_r;
    out_valid_nxt     = out_valid_r;
    out_data_nxt      = out_data_r;
    if (advance) begin
      out_valid_nxt = 1'b0;
      if (s2_vld_r) begin
        if (ctrl_r.do_score) begin
          case (ctrl_r.mode)
            sbhs_pkg::MODE_MOMS, sbhs_pkg::MODE_BOHM: begin
              if (mf_lt || (mf_eq && (h_gt || (h_eq && w_gt)))) begin
                best_min_free_nxt = min_free_r;
                best_weight_nxt   = wsum_r;
                bw_vld_nxt        = 1'b1;
                best_var_nxt      = ctrl_r.var_index;
                best_value_nxt    = !p_gt_n_r;
                best_score_nxt    = h_sel;
                bs_vld_nxt        = 1'b1;
                have_best_nxt     = 1'b1;
              end
            end
            sbhs_pkg::MODE_TWO_SIDED, sbhs_pkg::MODE_DLCS: begin
              if (s_gt) begin
                best_var_nxt   = ctrl_r.var_index;
                best_value_nxt = (ctrl_r.mode == sbhs_pkg::MODE_TWO_SIDED) ?
                                 (t_r >= f_r) : (t_r > f_r);
                best_score_nxt = s_sum;
                bs_vld_nxt     = 1'b1;
                have_best_nxt  = 1'b1;
              end
            end
            default: begin
              if ((t_r >= f_r) && t_gt) begin
                best_var_nxt   = ctrl_r.var_index;
                best_value_nxt = 1'b1;
                best_score_nxt = t_ext;
                bs_vld_nxt     = 1'b1;
                have_best_nxt  = 1'b1;
              end else if ((f_r >= t_r) && f_gt) begin
                best_var_nxt   = ctrl_r.var_index;
                best_value_nxt = 1'b0;
                best_score_nxt = f_ext;
                bs_vld_nxt     = 1'b1;
                have_best_nxt  = 1'b1;
              end
            end
          endcase
        end
        if (ctrl_r.scan_end) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.found        = have_best_nxt;
          out_data_nxt.chosen_var   = have_best_nxt ? best_var_nxt : '0;
          out_data_nxt.chosen_value = have_best_nxt && best_value_nxt;
          best_score_nxt    = '0;
          bs_vld_nxt        = 1'b0;
          best_weight_nxt   = '0;
          bw_vld_nxt        = 1'b0;
          best_min_free_nxt = clause_count;
          best_var_nxt      = '0;
          best_value_nxt    = 1'b0;
          have_best_nxt     = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r        <= 1'b0;
      best_score_r    <= '0;
      bs_vld_r        <= 1'b0;
      best_weight_r   <= '0;
      bw_vld_r        <= 1'b0;
      best_min_free_r <= sbhs_pkg::CLAUSE_COUNT_RESET;
      best_var_r      <= '0;
      best_value_r    <= 1'b0;
      have_best_r     <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (advance) begin
        s2_vld_r <= req_vld;
      end
      best_score_r    <= best_score_nxt;
      bs_vld_r        <= bs_vld_nxt;
      best_weight_r   <= best_weight_nxt;
      bw_vld_r        <= bw_vld_nxt;
      best_min_free_r <= best_min_free_nxt;
      best_var_r      <= best_var_nxt;
      best_value_r    <= best_value_nxt;
      have_best_r     <= have_best_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

### rtl/sat_branching_heuristic_scorer.sv
// ----------------------------------------------------------------------------
// SAT branching heuristic scorer
// Picks a branching variable and value from a stream of literal occurrences.
// ----------------------------------------------------------------------------
// Takes one occurrence per cycle into a four-entry queue while it is not full;
// the back end drains one entry per cycle, unless a held output stalls it,
// through the accumulate stage, the product register of the scoring stage and
// the best-candidate compare stage, each registered, before a decision shows on
// the output. Only a held output stalls the back end; the queue then keeps
// taking up to four more items. No clearing pass after reset.
module sat_branching_heuristic_scorer #(
  parameter int WEIGHT_SIZE = sbhs_pkg::WEIGHT_SIZE_DEF,
  parameter int COUNT_BITS  = sbhs_pkg::COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  sbhs_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output sbhs_pkg::out_item_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [sbhs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [sbhs_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  logic [sbhs_pkg::MODE_BITS-1:0]   heuristic_mode_r;
  logic [sbhs_pkg::CLAUSE_BITS-1:0] clause_count_r;

  sbhs_pkg::entry_t    front_entry, head;
  logic                q_full, q_empty, push, pop, advance;
  logic                req_vld;
  sbhs_pkg::req_ctrl_t req_ctrl;
  logic [COUNT_BITS-1:0]             req_pos_count, req_neg_count;
  logic [sbhs_pkg::WEIGHT_BITS-1:0]  req_pos_weight, req_neg_weight;
  logic [sbhs_pkg::CLAUSE_BITS-1:0]  req_min_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heuristic_mode_r <= '0;
      clause_count_r   <= sbhs_pkg::CLAUSE_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sbhs_pkg::CFG_HEURISTIC_MODE: heuristic_mode_r <= cfg_data[sbhs_pkg::MODE_BITS-1:0];
        sbhs_pkg::CFG_CLAUSE_COUNT:   clause_count_r   <= cfg_data[sbhs_pkg::CLAUSE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign advance  = !out_valid || out_ready;

  sbhs_front #(
    .WEIGHT_SIZE (WEIGHT_SIZE)
  ) u_front (
    .in_item  (in_data),
    .mode_raw (heuristic_mode_r),
    .entry    (front_entry)
  );

  sbhs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_entry),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  sbhs_accum #(
    .WEIGHT_SIZE (WEIGHT_SIZE),
    .COUNT_BITS  (COUNT_BITS)
  ) u_accum (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (advance),
    .entry_vld        (!q_empty),
    .entry            (head),
    .clause_count     (clause_count_r),
    .pop              (pop),
    .req_vld_r        (req_vld),
    .req_ctrl_r       (req_ctrl),
    .req_pos_count_r  (req_pos_count),
    .req_neg_count_r  (req_neg_count),
    .req_pos_weight_r (req_pos_weight),
    .req_neg_weight_r (req_neg_weight),
    .req_min_free_r   (req_min_free)
  );

  sbhs_select #(
    .COUNT_BITS (COUNT_BITS)
  ) u_select (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .clause_count   (clause_count_r),
    .req_vld        (req_vld),
    .req_ctrl       (req_ctrl),
    .req_pos_count  (req_pos_count),
    .req_neg_count  (req_neg_count),
    .req_pos_weight (req_pos_weight),
    .req_neg_weight (req_neg_weight),
    .req_min_free   (req_min_free),
    .out_valid_r    (out_valid),
    .out_data_r     (out_data)
  );

endmodule

### rtl/sat_branching_heuristic_scorer_chk.sv
// ----------------------------------------------------------------------------
// SAT branching heuristic scorer port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "sat_branching_heuristic_scorer_assert.svh"

module sat_branching_heuristic_scorer_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input sbhs_pkg::in_item_t                  in_data,
  input logic                                out_valid,
  input logic                                out_ready,
  input sbhs_pkg::out_item_t                 out_data
);

  `SBHS_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data))
  `SBHS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `SBHS_ASSERT_IMPLIES(a_no_choice_zero, out_valid && !out_data.found, (out_data.chosen_var == '0) && !out_data.chosen_value)
  `SBHS_ASSERT_AFTER_RESET(a_reset_empty, !out_valid && in_ready)

endmodule

bind sat_branching_heuristic_scorer sat_branching_heuristic_scorer_chk u_chk (.*);
